>>> rtl/core/chd_pkg.sv
// Shared types and constants for the cartridge header decoder.
// No dependencies; used by cartridge_header_decoder and chd_checker.
package chd_pkg;

    localparam int unsigned CHD_HDR_LEN    = 16;
    localparam int unsigned CHD_KEEP_FIRST = 4;
    localparam int unsigned CHD_KEEP_COUNT = 8;
    localparam int unsigned CHD_MAGIC_LEN  = 4;
    localparam int unsigned CHD_CNT_W      = 5;
    localparam int unsigned CHD_TDATA_W    = 240;

    localparam logic [7:0] CHD_MAGIC [CHD_MAGIC_LEN] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

    localparam logic [7:0]  CHD_EXT_MASK     = 8'h0C;
    localparam logic [7:0]  CHD_EXT_CODE     = 8'h08;
    localparam logic [3:0]  CHD_ROM_EXP_CODE = 4'hF;
    localparam logic [3:0]  CHD_PRG_UNIT_SH  = 4'd14;  // 0x4000
    localparam logic [3:0]  CHD_CHR_UNIT_SH  = 4'd13;  // 0x2000
    localparam logic [21:0] CHD_LEGACY_RAM   = 22'h2000;
    localparam logic [21:0] CHD_RAM_BASE     = 22'd64;

    localparam logic [1:0] CHD_MIRROR_FOUR = 2'd2;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic [21:0] pattern_nvram_bytes;
        logic [21:0] prog_nvram_bytes;
        logic [21:0] pattern_ram_bytes;
        logic [21:0] prog_ram_bytes;
        logic [63:0] pattern_rom_bytes;
        logic [63:0] prog_rom_bytes;
        logic [3:0]  submapper_id;
        logic [11:0] mapper_id;
        logic [1:0]  mirror_mode;
        logic [2:0]  cart_flags;
        logic        header_ok;
    } t_result;

    // Extended ROM size: unit count, or (2*M+1) << E saturating at 64 bits.
    function automatic logic [63:0] rom_size(logic [7:0] lsb, logic [3:0] msb,
                                             logic [3:0] unit_sh);
        logic [66:0] prod;
        prod = 67'({lsb[1:0], 1'b1}) << lsb[7:2];
        if (msb == CHD_ROM_EXP_CODE) begin
            return (|prod[66:64]) ? '1 : prod[63:0];
        end
        return 64'({msb, lsb}) << unit_sh;
    endfunction

    function automatic logic [21:0] ram_size(logic [3:0] n);
        return (n == 4'd0) ? '0 : (CHD_RAM_BASE << n);
    endfunction

endpackage

>>> rtl/core/cartridge_header_decoder.sv
// Cartridge header decoder top level: byte counter, field store, decode.
// Depends on chd_pkg.
//
//  channel   dir  tdata                         tuser
//  s_axis    in   header_byte[7:0]              first_byte
//  m_axis    out  t_result (240 bits, see pkg)  -
//
// One byte beat accepted per cycle; the result beat is registered in the cycle
// after the sixteenth byte is accepted. Reset is synchronous, active low, and
// clears the count and output valid, sets the magic flag. Input stalls only
// while a result is still waiting and the count stands at the sixteenth byte,
// whether or not the waiting beat is marked as a new header.
module cartridge_header_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] header_byte
    input  logic                             i_s_axis_tuser,  // [0] first_byte
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] header_ok, [3:1] cart_flags, [5:4] mirror_mode, [17:6] mapper_id,
    // [21:18] submapper_id, [85:22] prog_rom_bytes, [149:86] pattern_rom_bytes,
    // [171:150] prog_ram_bytes, [193:172] pattern_ram_bytes,
    // [215:194] prog_nvram_bytes, [237:216] pattern_nvram_bytes, [239:238] zero
    output logic [chd_pkg::CHD_TDATA_W-1:0]  o_m_axis_tdata
);
    import chd_pkg::*;

    logic [CHD_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_magic, n_magic;
    logic [7:0]           r_field [CHD_KEEP_COUNT];
    logic                 r_out_valid, n_out_valid;
    t_result              r_out;
    t_result              dec;

    logic                 accept;
    logic [CHD_CNT_W-1:0] cnt_eff;
    logic                 magic_eff;
    logic                 last_beat;

    assign o_s_axis_tready = !(r_out_valid && !i_m_axis_tready &&
                               r_cnt == CHD_CNT_W'(CHD_HDR_LEN - 1));
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign cnt_eff   = i_s_axis_tuser ? '0 : r_cnt;
    assign magic_eff = i_s_axis_tuser ? 1'b1 : r_magic;
    assign last_beat = accept && (cnt_eff == CHD_CNT_W'(CHD_HDR_LEN - 1));

    always_comb begin
        n_cnt   = r_cnt;
        n_magic = r_magic;
        if (accept) begin
            n_magic = magic_eff;
            if (cnt_eff < CHD_CNT_W'(CHD_HDR_LEN)) begin
                n_cnt = cnt_eff + CHD_CNT_W'(1);
                if (cnt_eff < CHD_CNT_W'(CHD_MAGIC_LEN) &&
                    i_s_axis_tdata != CHD_MAGIC[cnt_eff[1:0]]) begin
                    n_magic = 1'b0;
                end
            end else begin
                n_cnt = CHD_CNT_W'(CHD_HDR_LEN);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (last_beat) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Decode from stored bytes 4..11; byte 15 itself carries nothing.
    always_comb begin
        logic [7:0] b4, b5, b6, b7, b8, b9, b10, b11;
        logic       ext, battery, trainer;
        b4  = r_field[0];
        b5  = r_field[1];
        b6  = r_field[2];
        b7  = r_field[3];
        b8  = r_field[4];
        b9  = r_field[5];
        b10 = r_field[6];
        b11 = r_field[7];
        ext     = (b7 & CHD_EXT_MASK) == CHD_EXT_CODE;
        battery = b6[1];
        trainer = b6[2];

        dec             = '0;
        dec.header_ok   = magic_eff;
        dec.cart_flags  = {ext, trainer, battery};
        dec.mirror_mode = b6[3] ? CHD_MIRROR_FOUR : {1'b0, b6[0]};
        dec.mapper_id   = {ext ? b8[3:0] : 4'd0, b7[7:4], b6[7:4]};
        if (ext) begin
            dec.submapper_id        = b8[7:4];
            dec.prog_rom_bytes      = rom_size(b4, b9[3:0], CHD_PRG_UNIT_SH);
            dec.pattern_rom_bytes   = rom_size(b5, b9[7:4], CHD_CHR_UNIT_SH);
            dec.prog_ram_bytes      = ram_size(b10[3:0]);
            dec.prog_nvram_bytes    = ram_size(b10[7:4]);
            dec.pattern_ram_bytes   = ram_size(b11[3:0]);
            dec.pattern_nvram_bytes = ram_size(b11[7:4]);
        end else begin
            dec.prog_rom_bytes      = 64'(b4) << CHD_PRG_UNIT_SH;
            dec.pattern_rom_bytes   = 64'(b5) << CHD_CHR_UNIT_SH;
            dec.prog_ram_bytes      = (b8 == 8'd0) ? CHD_LEGACY_RAM
                                                   : (22'(b8) << CHD_CHR_UNIT_SH);
            dec.pattern_ram_bytes   = (b5 == 8'd0) ? CHD_LEGACY_RAM : '0;
            dec.prog_nvram_bytes    = battery ? CHD_LEGACY_RAM : '0;
            dec.pattern_nvram_bytes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_magic     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_magic     <= n_magic;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cnt_eff >= CHD_CNT_W'(CHD_KEEP_FIRST) &&
            cnt_eff < CHD_CNT_W'(CHD_KEEP_FIRST + CHD_KEEP_COUNT)) begin
            r_field[3'(cnt_eff - CHD_CNT_W'(CHD_KEEP_FIRST))] <= i_s_axis_tdata;
        end
        if (last_beat) begin
            r_out <= dec;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

endmodule

>>> rtl/core/chd_checker.sv
// Port-level checks for cartridge_header_decoder, bound to the top level.
// Depends on chd_pkg.
module chd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [chd_pkg::CHD_TDATA_W-1:0]  o_m_axis_tdata
);
    import chd_pkg::*;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

    // a new result only follows an accepted byte
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready))
        else $error("result beat without an accepted byte");

    // input only backs up behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled with output free");

endmodule

bind cartridge_header_decoder chd_checker u_chd_checker (.*);

>>> tb/cartridge_header_decoder_tb.sv
// Self-checking testbench for cartridge_header_decoder: directed header table, then
// random byte streams, each result beat checked against a behavioural model or a typed row.
// Depends on chd_pkg and the cartridge_header_decoder RTL.
`timescale 1ns / 100ps

module cartridge_header_decoder_tb;
    import chd_pkg::*;

    localparam int unsigned ITEMS       = 1450;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_DIR       = 11;

    localparam logic [2:0] FLAG_BATTERY = 3'b001;
    localparam logic [2:0] FLAG_TRAINER = 3'b010;
    localparam logic [2:0] FLAG_EXT     = 3'b100;
    localparam logic [1:0] MIRROR_HORIZ = 2'd0;

    typedef struct packed {
        logic [7:0] data;
        logic       mark;
        logic       typed;
        t_result    want;
    } t_hdr_beat;

    typedef struct packed {
        logic [127:0] hdr;   // byte 0 in the top bits
        logic [4:0]   len;
        logic         mark;
        logic         typed;
        t_result      want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata = '0;  // [7:0] header_byte
    logic                   i_s_axis_tuser = 1'b0;  // [0] first_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [CHD_TDATA_W-1:0] o_m_axis_tdata;  // t_result, header_ok in bit 0

    cartridge_header_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_hdr_beat   byte_q [$];
    t_result     decoded_q [$];
    t_hdr_beat   cur_beat;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned mismatches = 0;
    int unsigned bytes_in = 0;
    int unsigned headers_out = 0;
    int unsigned n_ext = 0;
    int unsigned n_bad_magic = 0;
    int unsigned n_saturated = 0;
    int unsigned cycle_cnt = 0;

    // decoder model state
    logic [4:0] byte_idx = '0;
    logic       magic_seen = 1'b1;
    logic [7:0] kept [CHD_KEEP_COUNT];

    function automatic logic [63:0] rom_bytes(logic [7:0] lsb, logic [3:0] msb,
                                              int unsigned unit_sh);
        logic [127:0] wide;
        if (msb == CHD_ROM_EXP_CODE) begin
            wide = {125'd0, lsb[1:0], 1'b1} << lsb[7:2];
            return (wide[127:64] != '0) ? {64{1'b1}} : wide[63:0];
        end
        return {52'd0, msb, lsb} << unit_sh;
    endfunction

    function automatic logic [21:0] ram_bytes(logic [3:0] n);
        return (n == 4'd0) ? 22'd0 : (CHD_RAM_BASE << n);
    endfunction

    function automatic t_result mk_result(logic ok, logic [2:0] flags, logic [1:0] mir,
                                          logic [11:0] mapper, logic [3:0] sub,
                                          logic [63:0] prom, logic [63:0] crom,
                                          logic [21:0] pram, logic [21:0] cram,
                                          logic [21:0] pnv, logic [21:0] cnv);
        t_result r;
        r = '0;
        r.header_ok           = ok;
        r.cart_flags          = flags;
        r.mirror_mode         = mir;
        r.mapper_id           = mapper;
        r.submapper_id        = sub;
        r.prog_rom_bytes      = prom;
        r.pattern_rom_bytes   = crom;
        r.prog_ram_bytes      = pram;
        r.pattern_ram_bytes   = cram;
        r.prog_nvram_bytes    = pnv;
        r.pattern_nvram_bytes = cnv;
        return r;
    endfunction

    function automatic t_dir_row dir_row(logic [127:0] hdr, int unsigned len, logic mark,
                                         logic typed, t_result want);
        t_dir_row r;
        r.hdr   = hdr;
        r.len   = len[4:0];
        r.mark  = mark;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // One header byte through the model; fire is set on the sixteenth byte.
    task automatic decode_byte(input logic [7:0] hb_in, input logic mark,
                               output bit fire, output t_result r);
        logic [4:0]  idx;
        logic [7:0]  b4, b5, b6, b7, b8, b9, b10, b11;
        logic        ext, bat, trn;
        logic [2:0]  flags;
        logic [11:0] mapper;
        fire = 1'b0;
        r = '0;
        if (mark) begin
            byte_idx = '0;
            magic_seen = 1'b1;
        end
        if (byte_idx >= CHD_HDR_LEN) begin
            byte_idx = 5'(CHD_HDR_LEN);
            return;
        end
        idx = byte_idx;
        byte_idx = byte_idx + 5'd1;
        if (idx < CHD_MAGIC_LEN) begin
            if (hb_in != CHD_MAGIC[idx[1:0]]) magic_seen = 1'b0;
        end else if (idx < CHD_KEEP_FIRST + CHD_KEEP_COUNT) begin
            kept[3'(idx - 5'(CHD_KEEP_FIRST))] = hb_in;
        end
        if (idx != CHD_HDR_LEN - 1) return;

        b4 = kept[0]; b5 = kept[1]; b6 = kept[2];  b7 = kept[3];
        b8 = kept[4]; b9 = kept[5]; b10 = kept[6]; b11 = kept[7];
        ext = (b7 & CHD_EXT_MASK) == CHD_EXT_CODE;
        bat = b6[1];
        trn = b6[2];
        flags = (bat ? FLAG_BATTERY : 3'b000) | (trn ? FLAG_TRAINER : 3'b000)
              | (ext ? FLAG_EXT : 3'b000);
        mapper = {4'd0, b7[7:4], b6[7:4]};
        fire = 1'b1;
        if (ext) begin
            mapper[11:8] = b8[3:0];
            r = mk_result(magic_seen, flags, b6[3] ? CHD_MIRROR_FOUR : {1'b0, b6[0]},
                          mapper, b8[7:4],
                          rom_bytes(b4, b9[3:0], CHD_PRG_UNIT_SH),
                          rom_bytes(b5, b9[7:4], CHD_CHR_UNIT_SH),
                          ram_bytes(b10[3:0]), ram_bytes(b11[3:0]),
                          ram_bytes(b10[7:4]), ram_bytes(b11[7:4]));
        end else begin
            r = mk_result(magic_seen, flags, b6[3] ? CHD_MIRROR_FOUR : {1'b0, b6[0]},
                          mapper, 4'd0,
                          {42'd0, b4, 14'd0}, {43'd0, b5, 13'd0},
                          (b8 == 8'd0) ? CHD_LEGACY_RAM : {1'b0, b8, 13'd0},
                          (b5 == 8'd0) ? CHD_LEGACY_RAM : 22'd0,
                          bat ? CHD_LEGACY_RAM : 22'd0, 22'd0);
        end
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("header %0d: %s expected %0h, got %0h",
                         headers_out, name, want_v, got_v);
        end
    endtask

    // sender and input-side model
    always @(posedge i_clk) begin : sender
        bit      fire;
        t_result res;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            byte_idx = '0;
            magic_seen = 1'b1;
            for (int k = 0; k < CHD_KEEP_COUNT; k++) kept[k] = '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                bytes_in++;
                decode_byte(cur_beat.data, cur_beat.mark, fire, res);
                if (fire) begin
                    if (cur_beat.typed) res = cur_beat.want;
                    if (res.cart_flags[2]) n_ext++;
                    if (!res.header_ok) n_bad_magic++;
                    if (&res.prog_rom_bytes || &res.pattern_rom_bytes) n_saturated++;
                    decoded_q.push_back(res);
                end
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    cur_beat = byte_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= cur_beat.data;
                    i_s_axis_tuser  <= cur_beat.mark;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and result checker
    always @(posedge i_clk) begin : receiver
        t_result want, got;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                headers_out++;
                got = o_m_axis_tdata;
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("header %0d: unexpected result beat %0h",
                                 headers_out, o_m_axis_tdata);
                end else begin
                    want = decoded_q.pop_front();
                    cmp_field("header_ok", 64'(want.header_ok), 64'(got.header_ok));
                    cmp_field("cart_flags", 64'(want.cart_flags), 64'(got.cart_flags));
                    cmp_field("mirror_mode", 64'(want.mirror_mode),
                              64'(got.mirror_mode));
                    cmp_field("mapper_id", 64'(want.mapper_id), 64'(got.mapper_id));
                    cmp_field("submapper_id", 64'(want.submapper_id),
                              64'(got.submapper_id));
                    cmp_field("prog_rom_bytes", want.prog_rom_bytes, got.prog_rom_bytes);
                    cmp_field("pattern_rom_bytes", want.pattern_rom_bytes,
                              got.pattern_rom_bytes);
                    cmp_field("prog_ram_bytes", 64'(want.prog_ram_bytes),
                              64'(got.prog_ram_bytes));
                    cmp_field("pattern_ram_bytes", 64'(want.pattern_ram_bytes),
                              64'(got.pattern_ram_bytes));
                    cmp_field("prog_nvram_bytes", 64'(want.prog_nvram_bytes),
                              64'(got.prog_nvram_bytes));
                    cmp_field("pattern_nvram_bytes", 64'(want.pattern_nvram_bytes),
                              64'(got.pattern_nvram_bytes));
                    cmp_field("pad", 64'(want.pad), 64'(got.pad));
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        t_dir_row    dir_tab [N_DIR];
        t_hdr_beat   bt;
        logic [7:0]  hb [CHD_HDR_LEN];
        int unsigned made, len, kind, extra;
        logic        marked;

        // unmarked start after reset, magic then zeros
        dir_tab[0]  = dir_row(128'h4E45531A_00000000_00000000_00000000, 16, 1'b0, 1'b1,
                              mk_result(1'b1, 3'b000, MIRROR_HORIZ, 12'h000, 4'h0, 64'd0,
                                        64'd0, CHD_LEGACY_RAM, CHD_LEGACY_RAM, 22'd0, 22'd0));
        // stray bytes past the sixteenth: ignored
        dir_tab[1]  = dir_row(128'hA55AFF00_00000000_00000000_00000000, 3, 1'b0, 1'b0, '0);
        // legacy, every field byte all ones
        dir_tab[2]  = dir_row(128'h4E45531A_FFFFFFFF_FFFFFFFF_FFFFFFFF, 16, 1'b1, 1'b1,
                              mk_result(1'b1, FLAG_BATTERY | FLAG_TRAINER, CHD_MIRROR_FOUR,
                                        12'h0FF, 4'h0, 64'h3F_C000, 64'h1F_E000,
                                        22'h1F_E000, 22'd0, CHD_LEGACY_RAM, 22'd0));
        // bad magic, all zeros
        dir_tab[3]  = dir_row(128'h0, 16, 1'b1, 1'b1,
                              mk_result(1'b0, 3'b000, MIRROR_HORIZ, 12'h000, 4'h0, 64'd0,
                                        64'd0, CHD_LEGACY_RAM, CHD_LEGACY_RAM, 22'd0, 22'd0));
        // header cut short, then restarted by a mark
        dir_tab[4]  = dir_row(128'h4E45531A_01020300_00000000_00000000, 7, 1'b1, 1'b0, '0);
        // extended, both ROM sizes saturate, RAM sizes at maximum
        dir_tab[5]  = dir_row(128'h4E45531A_FFFF0008_FFFFFFFF_00000000, 16, 1'b1, 1'b1,
                              mk_result(1'b1, FLAG_EXT, MIRROR_HORIZ, 12'hF00, 4'hF,
                                        {64{1'b1}}, {64{1'b1}}, 22'h20_0000, 22'h20_0000,
                                        22'h20_0000, 22'h20_0000));
        // extended exponent sizes, one just inside the 64-bit range
        dir_tab[6]  = dir_row(128'h4E45531A_F7003958_21FF1001_00000000, 16, 1'b1, 1'b0, '0);
        // extended exponent, both sizes just inside the range
        dir_tab[7]  = dir_row(128'h4E45531A_F9FC0608_00FF0000_00000000, 16, 1'b1, 1'b0, '0);
        // extended unit-count sizes at their largest
        dir_tab[8]  = dir_row(128'h4E45531A_FFFFF2F8_0FEEF0FF_FFFFFFFF, 16, 1'b1, 1'b0, '0);
        // legacy, vertical mirroring, near-extended format bits
        dir_tab[9]  = dir_row(128'h4E45531A_10000104_00000000_00000000, 16, 1'b1, 1'b0, '0);
        // last magic byte wrong
        dir_tab[10] = dir_row(128'h4E45531B_02010A00_05000000_00000000, 16, 1'b1, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle = 24;
                    recv_idle = 79;
                end
                1: begin
                    send_idle = 79;
                    recv_idle = 24;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase

            if (p == 0) begin
                for (int r = 0; r < N_DIR; r++) begin
                    for (int i = 0; i < dir_tab[r].len; i++) begin
                        bt.data  = dir_tab[r].hdr[127 - 8*i -: 8];
                        bt.mark  = dir_tab[r].mark && (i == 0);
                        bt.typed = dir_tab[r].typed && (i == CHD_HDR_LEN - 1);
                        bt.want  = dir_tab[r].want;
                        byte_q.push_back(bt);
                    end
                end
            end

            made = byte_q.size();
            while (made < ITEMS / 3) begin
                kind = $urandom_range(99);
                for (int i = 0; i < CHD_HDR_LEN; i++)
                    hb[i] = (i < CHD_MAGIC_LEN) ? CHD_MAGIC[i] : 8'($urandom_range(255));
                if ($urandom_range(9) == 0) hb[4'($urandom_range(3))] = 8'($urandom_range(255));
                if ($urandom_range(1)) hb[7][3:2] = 2'b10;
                if ($urandom_range(3) == 0) hb[9][3:0] = CHD_ROM_EXP_CODE;
                if ($urandom_range(3) == 0) hb[9][7:4] = CHD_ROM_EXP_CODE;
                if ($urandom_range(5) == 0) hb[8] = 8'd0;
                if ($urandom_range(5) == 0) hb[5] = 8'd0;
                extra = 0;
                marked = 1'b1;
                if (kind < 75) begin
                    len = CHD_HDR_LEN;
                    extra = $urandom_range(2);
                end else if (kind < 88) begin
                    len = $urandom_range(CHD_HDR_LEN - 1, 1);
                end else begin
                    len = $urandom_range(CHD_HDR_LEN, 1);
                    marked = 1'b0;
                    for (int i = 0; i < CHD_HDR_LEN; i++) hb[i] = 8'($urandom_range(255));
                end
                for (int i = 0; i < len + extra; i++) begin
                    bt.data  = (i < len) ? hb[i] : 8'($urandom_range(255));
                    bt.mark  = marked ? (i == 0) : ($urandom_range(7) == 0);
                    bt.typed = 1'b0;
                    bt.want  = '0;
                    byte_q.push_back(bt);
                end
                made += len + extra;
            end

            while (byte_q.size() != 0 || i_s_axis_tvalid || decoded_q.size() != 0)
                @(posedge i_clk);
        end

        repeat (8) @(posedge i_clk);
        if (decoded_q.size() != 0)
            $display("%0d decoded headers never came out", decoded_q.size());
        $display("%0d header bytes in, %0d result beats checked over %0d cycles",
                 bytes_in, headers_out, cycle_cnt);
        $display("%0d extended, %0d bad magic, %0d with a saturated ROM size",
                 n_ext, n_bad_magic, n_saturated);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
